@@ rtl/core/lppv_pkg.sv @@
// ----------------------------------------------------------------------------
// lppv_pkg
// shared types and constants of the length-prefixed path validator
// ----------------------------------------------------------------------------
package lppv_pkg;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // register index, taken from paddr[2]
  localparam logic REG_MAX_COMPONENTS  = 1'b0;
  localparam logic REG_MAX_NAME_LENGTH = 1'b1;

  localparam logic [15:0] MAX_COMPONENTS_RST  = 16'd64;
  localparam logic [7:0]  MAX_NAME_LENGTH_RST = 8'd255;

  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_NUL    = 8'h00;

  localparam logic KIND_NAME    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  name_byte;
    logic [15:0] component_index;
    logic        component_end;
    logic        path_ok;
    logic [15:0] component_count;
    logic        end_of_run;
  } out_word_t;

  typedef struct packed {
    logic [1:0] count;
    out_word_t  word0;
    out_word_t  word1;
  } push_t;

endpackage

@@ rtl/core/lppv_parser.sv @@
// ----------------------------------------------------------------------------
// lppv_parser
// per-byte parse state and result word generation
// ----------------------------------------------------------------------------
module lppv_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  lppv_pkg::in_word_t   in_word,
  input  logic [15:0]          max_components,
  input  logic [7:0]           max_name_length,
  output lppv_pkg::push_t      push
);

  localparam logic [2:0] PH_CNT_HI = 3'd0;
  localparam logic [2:0] PH_CNT_LO = 3'd1;
  localparam logic [2:0] PH_RES0   = 3'd2;
  localparam logic [2:0] PH_RES1   = 3'd3;
  localparam logic [2:0] PH_LEN    = 3'd4;
  localparam logic [2:0] PH_NAME   = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;

  logic [2:0]  phase, phase_next;
  logic [15:0] declared_count, declared_count_next;
  logic [15:0] components_done, components_done_next;
  logic [7:0]  name_length, name_length_next;
  logic [7:0]  name_position, name_position_next;
  logic [1:0]  dot_flags, dot_flags_next;
  logic        rejected, rejected_next;

  logic [7:0]  b;
  logic [7:0]  pos_inc;
  logic [15:0] done_inc;
  logic        name_end;
  logic        fwd;
  logic        ok;
  lppv_pkg::out_word_t fwd_word;
  lppv_pkg::out_word_t verdict_word;

  assign b        = in_word.data_byte;
  assign pos_inc  = name_position + 8'd1;
  assign done_inc = components_done + 16'd1;
  assign name_end = (pos_inc == name_length);
  assign fwd      = !rejected && (phase == PH_NAME);

  always_comb begin
    phase_next           = phase;
    declared_count_next  = declared_count;
    components_done_next = components_done;
    name_length_next     = name_length;
    name_position_next   = name_position;
    dot_flags_next       = dot_flags;
    rejected_next        = rejected;
    if (!rejected) begin
      unique case (phase)
        PH_CNT_HI: begin
          declared_count_next = {b, 8'd0};
          phase_next          = PH_CNT_LO;
        end
        PH_CNT_LO: begin
          declared_count_next = {declared_count[15:8], b};
          if ({declared_count[15:8], b} > max_components) begin
            rejected_next = 1'b1;
          end else if ({declared_count[15:8], b} == 16'd0) begin
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_RES0;
          end
        end
        PH_RES0: phase_next = PH_RES1;
        PH_RES1: phase_next = PH_LEN;
        PH_LEN: begin
          name_length_next   = b;
          name_position_next = 8'd0;
          dot_flags_next     = 2'b00;
          if (b == 8'd0 || b > max_name_length) begin
            rejected_next = 1'b1;
          end else begin
            phase_next = PH_NAME;
          end
        end
        PH_NAME: begin
          if (b == lppv_pkg::CHAR_DOT) begin
            if (name_position == 8'd0) begin
              dot_flags_next[0] = 1'b1;
            end else if (name_position == 8'd1) begin
              dot_flags_next[1] = 1'b1;
            end
          end
          if (b == lppv_pkg::CHAR_SLASH || b == lppv_pkg::CHAR_BSLASH ||
              b == lppv_pkg::CHAR_NUL) begin
            rejected_next = 1'b1;
          end
          name_position_next = pos_inc;
          if (name_end) begin
            // lone "." or ".."
            if (name_length == 8'd1 && dot_flags_next == 2'b01) begin
              rejected_next = 1'b1;
            end
            if (name_length == 8'd2 && dot_flags_next == 2'b11) begin
              rejected_next = 1'b1;
            end
            components_done_next = done_inc;
            phase_next = (done_inc == declared_count) ? PH_DONE : PH_RES0;
          end
        end
        default: ;
      endcase
    end
  end

  assign ok = !rejected_next && (phase_next == PH_DONE);

  always_comb begin
    fwd_word                 = '0;
    fwd_word.out_kind        = lppv_pkg::KIND_NAME;
    fwd_word.name_byte       = b;
    fwd_word.component_index = components_done;
    fwd_word.component_end   = name_end;
    fwd_word.end_of_run      = !in_word.last_byte;

    verdict_word                 = '0;
    verdict_word.out_kind        = lppv_pkg::KIND_VERDICT;
    verdict_word.path_ok         = ok;
    verdict_word.component_count = ok ? declared_count_next : 16'd0;
    verdict_word.end_of_run      = 1'b1;

    push = '0;
    if (fire) begin
      push.count = {1'b0, fwd} + {1'b0, in_word.last_byte};
      push.word0 = fwd ? fwd_word : verdict_word;
      push.word1 = verdict_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_CNT_HI;
      declared_count  <= 16'd0;
      components_done <= 16'd0;
      name_length     <= 8'd0;
      name_position   <= 8'd0;
      dot_flags       <= 2'b00;
      rejected        <= 1'b0;
    end else if (fire) begin
      if (in_word.last_byte) begin
        // buffer end, start over
        phase           <= PH_CNT_HI;
        declared_count  <= 16'd0;
        components_done <= 16'd0;
        name_length     <= 8'd0;
        name_position   <= 8'd0;
        dot_flags       <= 2'b00;
        rejected        <= 1'b0;
      end else begin
        phase           <= phase_next;
        declared_count  <= declared_count_next;
        components_done <= components_done_next;
        name_length     <= name_length_next;
        name_position   <= name_position_next;
        dot_flags       <= dot_flags_next;
        rejected        <= rejected_next;
      end
    end
  end

endmodule

@@ rtl/core/lppv_out_fifo.sv @@
// ----------------------------------------------------------------------------
// lppv_out_fifo
// result queue taking up to two words per cycle and giving one on out_ready
// ----------------------------------------------------------------------------
module lppv_out_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  lppv_pkg::push_t      push,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lppv_pkg::out_word_t  out_word
);

  localparam int AW = lppv_pkg::FIFO_AW;
  localparam int CW = AW + 1;

  lppv_pkg::out_word_t mem [lppv_pkg::FIFO_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count, count_next;
  logic          pop;
  logic [AW-1:0] wr_ptr1;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_word  = mem[rd_ptr];
  assign room      = (count <= CW'(lppv_pkg::FIFO_DEPTH - 2));
  assign wr_ptr1   = wr_ptr + AW'(1);
  assign count_next = count + CW'(push.count) - CW'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.word0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr1] <= push.word1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count_next;
    end
  end

endmodule

@@ rtl/core/length_prefixed_path_validator.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_path_validator
// parses a length-prefixed path byte stream, forwards name bytes, gives a verdict
// ----------------------------------------------------------------------------
// throughput: one input word per cycle while in_ready is high, written into the
//   output queue at the edge that accepts it; a word that ends a name and the
//   buffer gives two result words, which leave the 4-word queue one per cycle
//   while out_ready is high; in_ready drops while fewer than two entries are free
// reset: synchronous rst clears the parse state and queue, registers to defaults
module length_prefixed_path_validator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lppv_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lppv_pkg::out_word_t                 out_word,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lppv_pkg::PADDR_W-1:0]        paddr,
  input  logic [lppv_pkg::PDATA_W-1:0]        pwdata,
  output logic [lppv_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  logic [15:0]     max_components;
  logic [7:0]      max_name_length;
  logic            fire;
  logic            room;
  lppv_pkg::push_t push;

  assign pready   = 1'b1;
  assign in_ready = room;
  assign fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_components  <= lppv_pkg::MAX_COMPONENTS_RST;
      max_name_length <= lppv_pkg::MAX_NAME_LENGTH_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        lppv_pkg::REG_MAX_COMPONENTS:  max_components  <= pwdata[15:0];
        lppv_pkg::REG_MAX_NAME_LENGTH: max_name_length <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      lppv_pkg::REG_MAX_COMPONENTS:  prdata = {16'd0, max_components};
      lppv_pkg::REG_MAX_NAME_LENGTH: prdata = {24'd0, max_name_length};
      default:                       prdata = '0;
    endcase
  end

  lppv_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .in_word         (in_word),
    .max_components  (max_components),
    .max_name_length (max_name_length),
    .push            (push)
  );

  lppv_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives serialized paths one byte word at a time into the path validator,
// predicts the forwarded name bytes and verdicts, checks each output word in
// order, and sweeps both limit registers under varied backpressure
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_WORDS = 140;
  localparam int NUM_DIRECTED = 24;

  localparam logic [15:0] COMP_SET [6] = '{16'd5, 16'd0, 16'hFFFF, 16'd3, 16'd1, 16'd16};
  localparam logic [7:0]  LEN_SET  [6] = '{8'd12, 8'd1, 8'd255, 8'd4, 8'd255, 8'd8};

  localparam logic [8:0] DIRECTED [NUM_DIRECTED] = '{
    // zero count, accepted at once
    {8'h00, 1'b0}, {8'h00, 1'b1},
    // one name that ends with the buffer
    {8'h00, 1'b0}, {8'h01, 1'b0}, {8'hFF, 1'b0}, {8'h00, 1'b0}, {8'h01, 1'b0},
    {8'h61, 1'b1},
    // count far above the limit
    {8'hFF, 1'b0}, {8'hFF, 1'b1},
    // slash rejects, later byte not forwarded
    {8'h00, 1'b0}, {8'h01, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h02, 1'b0},
    {lppv_pkg::CHAR_SLASH, 1'b0}, {8'h62, 1'b1},
    // trailing bytes ignored
    {8'h00, 1'b0}, {8'h00, 1'b0}, {8'hAB, 1'b0}, {8'hFF, 1'b1},
    // buffer ends early
    {8'h00, 1'b0}, {8'h02, 1'b0}, {8'h00, 1'b1}
  };

  typedef enum logic [2:0] {
    AT_COUNT_HI, AT_COUNT_LO, AT_RSVD0, AT_RSVD1, AT_LENGTH, AT_NAME, AT_TAIL
  } parse_phase_t;

  class path_scoreboard;
    logic [15:0]  comp_limit;
    logic [7:0]   len_limit;
    parse_phase_t phase;
    logic [15:0]  declared;
    logic [15:0]  done_count;
    logic [7:0]   name_size;
    logic [7:0]   name_pos;
    logic [1:0]   dots;
    bit           bad;
    lppv_pkg::out_word_t expected_words[$];
    int           errors;

    function new();
      errors = 0;
      comp_limit = lppv_pkg::MAX_COMPONENTS_RST;
      len_limit = lppv_pkg::MAX_NAME_LENGTH_RST;
      restart();
    endfunction

    function void restart();
      phase = AT_COUNT_HI;
      declared = '0;
      done_count = '0;
      name_size = '0;
      name_pos = '0;
      dots = '0;
      bad = 1'b0;
    endfunction

    function void set_register(logic idx, logic [31:0] value);
      if (idx == lppv_pkg::REG_MAX_COMPONENTS) comp_limit = value[15:0];
      else len_limit = value[7:0];
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void predict_byte(lppv_pkg::in_word_t w);
      lppv_pkg::out_word_t res[2];
      int         n;
      logic [7:0] b;
      logic [7:0] next_pos;
      bit         ends;
      bit         ok;
      n = 0;
      b = w.data_byte;
      if (!bad) begin
        case (phase)
          AT_COUNT_HI: begin
            declared = {b, 8'h00};
            phase = AT_COUNT_LO;
          end
          AT_COUNT_LO: begin
            declared = {declared[15:8], b};
            if (declared > comp_limit) bad = 1'b1;
            else if (declared == 16'd0) phase = AT_TAIL;
            else phase = AT_RSVD0;
          end
          AT_RSVD0: phase = AT_RSVD1;
          AT_RSVD1: phase = AT_LENGTH;
          AT_LENGTH: begin
            name_size = b;
            name_pos = '0;
            dots = '0;
            if (b == 8'd0 || b > len_limit) bad = 1'b1;
            else phase = AT_NAME;
          end
          AT_NAME: begin
            next_pos = name_pos + 8'd1;
            ends = (next_pos == name_size);
            if (b == lppv_pkg::CHAR_DOT) begin
              if (name_pos == 8'd0) dots[0] = 1'b1;
              else if (name_pos == 8'd1) dots[1] = 1'b1;
            end
            if (b == lppv_pkg::CHAR_SLASH || b == lppv_pkg::CHAR_BSLASH ||
                b == lppv_pkg::CHAR_NUL) bad = 1'b1;
            res[n] = '0;
            res[n].out_kind = lppv_pkg::KIND_NAME;
            res[n].name_byte = b;
            res[n].component_index = done_count;
            res[n].component_end = ends;
            n++;
            name_pos = next_pos;
            if (ends) begin
              if (name_size == 8'd1 && dots == 2'b01) bad = 1'b1;
              if (name_size == 8'd2 && dots == 2'b11) bad = 1'b1;
              done_count = done_count + 16'd1;
              phase = (done_count == declared) ? AT_TAIL : AT_RSVD0;
            end
          end
          default: ;
        endcase
      end
      if (w.last_byte) begin
        ok = !bad && phase == AT_TAIL;
        res[n] = '0;
        res[n].out_kind = lppv_pkg::KIND_VERDICT;
        res[n].path_ok = ok;
        res[n].component_count = ok ? declared : 16'd0;
        n++;
        restart();
      end
      if (n > 0) res[n-1].end_of_run = 1'b1;
      for (int i = 0; i < n; i++) expected_words.push_back(res[i]);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task compare(string field, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", field, got, want));
    endtask

    task check_word(lppv_pkg::out_word_t got);
      lppv_pkg::out_word_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("output word %h with nothing expected", got));
        return;
      end
      want = expected_words.pop_front();
      compare("out_kind", 16'(got.out_kind), 16'(want.out_kind));
      compare("name_byte", 16'(got.name_byte), 16'(want.name_byte));
      compare("component_index", got.component_index, want.component_index);
      compare("component_end", 16'(got.component_end), 16'(want.component_end));
      compare("path_ok", 16'(got.path_ok), 16'(want.path_ok));
      compare("component_count", got.component_count, want.component_count);
      compare("end_of_run", 16'(got.end_of_run), 16'(want.end_of_run));
    endtask
  endclass

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  lppv_pkg::in_word_t            in_word;
  logic                          out_valid;
  logic                          out_ready;
  lppv_pkg::out_word_t           out_word;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [lppv_pkg::PADDR_W-1:0]  paddr;
  logic [lppv_pkg::PDATA_W-1:0]  pwdata;
  logic [lppv_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  path_scoreboard     board;
  lppv_pkg::in_word_t path_words[$];
  int                 send_idle;
  int                 recv_idle;
  int                 hold_requests = 0;
  int                 words_sent;
  int                 cycles;

  length_prefixed_path_validator dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.predict_byte(in_word);
      if (out_valid && out_ready) board.check_word(out_word);
    end
  end

  // receiver: random stalls plus an occasional long hold
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_word(lppv_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_path();
    foreach (path_words[i]) send_word(path_words[i]);
  endtask

  task automatic write_register(logic idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_register(idx, value);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void add_word(logic [7:0] b, logic l);
    lppv_pkg::in_word_t w;
    w.data_byte = b;
    w.last_byte = l;
    path_words.push_back(w);
  endfunction

  function automatic logic [7:0] name_char();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return 8'h61 + 8'($urandom_range(25));
    if (pick < 80) return lppv_pkg::CHAR_DOT;
    if (pick < 83) begin
      case ($urandom_range(2))
        0: return lppv_pkg::CHAR_SLASH;
        1: return lppv_pkg::CHAR_BSLASH;
        default: return lppv_pkg::CHAR_NUL;
      endcase
    end
    return 8'($urandom);
  endfunction

  function automatic void add_component();
    int         pick;
    int         len;
    logic [7:0] lim;
    lim = board.len_limit;
    add_word(8'($urandom), 1'b0);
    add_word(8'($urandom), 1'b0);
    pick = $urandom_range(99);
    if (pick < 4) len = 0;
    else if (pick < 8 && lim != 8'hFF) len = lim + 1;
    else if (pick < 10) len = lim;
    else len = $urandom_range((lim < 6) ? lim : 6, 1);
    add_word(8'(len), 1'b0);
    pick = $urandom_range(99);
    if (len == 1 && pick < 25) begin
      add_word(lppv_pkg::CHAR_DOT, 1'b0);
    end else if (len == 2 && pick < 25) begin
      add_word(lppv_pkg::CHAR_DOT, 1'b0);
      add_word(lppv_pkg::CHAR_DOT, 1'b0);
    end else begin
      repeat (len) add_word(name_char(), 1'b0);
    end
  endfunction

  function automatic void build_random_path();
    int                 pick;
    int                 emit_n;
    int                 cut;
    logic [15:0]        cnt;
    logic [15:0]        lim;
    lppv_pkg::in_word_t w;
    path_words.delete();
    lim = board.comp_limit;
    pick = $urandom_range(99);
    if (pick < 10) begin
      repeat ($urandom_range(12, 1)) add_word(8'($urandom), 1'b0);
    end else begin
      pick = $urandom_range(99);
      if (pick < 8) cnt = 16'd0;
      else if (pick < 15) cnt = (lim == 16'hFFFF) ? 16'hFFFF
                                                   : 16'($urandom_range(65535, lim + 1));
      else if (lim == 16'd0) cnt = 16'd0;
      else cnt = 16'($urandom_range((lim < 4) ? lim : 4, 1));
      add_word(cnt[15:8], 1'b0);
      add_word(cnt[7:0], 1'b0);
      emit_n = (cnt <= 16'd4) ? int'(cnt) : $urandom_range(2);
      repeat (emit_n) add_component();
      if ($urandom_range(99) < 8) begin
        cut = $urandom_range(path_words.size(), 1);
        while (path_words.size() > cut) void'(path_words.pop_back());
      end
      if ($urandom_range(99) < 15) repeat ($urandom_range(3, 1)) add_word(8'($urandom), 1'b0);
    end
    w = path_words.pop_back();
    w.last_byte = 1'b1;
    path_words.push_back(w);
  endfunction

  initial begin
    board = new();
    words_sent = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_word <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    send_idle = 23;
    recv_idle <= 52;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    path_words.delete();
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      path_words.push_back(lppv_pkg::in_word_t'(DIRECTED[i]));
    end
    send_path();
    settle();

    for (int p = 0; p < 6; p++) begin
      write_register(lppv_pkg::REG_MAX_COMPONENTS, 32'(COMP_SET[p]));
      write_register(lppv_pkg::REG_MAX_NAME_LENGTH, 32'(LEN_SET[p]));
      case (p / 2)
        0: begin
          send_idle = 23;
          recv_idle <= 52;
        end
        1: begin
          send_idle = 52;
          recv_idle <= 23;
        end
        default: begin
          send_idle = 0;
          recv_idle <= 0;
        end
      endcase
      if (p == 2 || p == 5) hold_requests <= hold_requests + 1;
      words_sent = 0;
      while (words_sent < PHASE_WORDS) begin
        build_random_path();
        send_path();
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (board.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
